[design/drgb_pixel_packet_decoder_macros.svh]
// Assertion macros shared by the decoder checker.
`ifndef DRGB_PIXEL_PACKET_DECODER_MACROS_SVH
`define DRGB_PIXEL_PACKET_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DRGB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/drgb_pkg.sv]
// Types, codes and helpers shared by the DRGB packet decoder modules.
package drgb_pkg;

   localparam int INDEX_W     = 12;  // widest pixel index carried in the queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [7:0]  PROTOCOL_DRGB = 8'd2;
   localparam logic [15:0] MIN_LENGTH    = 16'd5;
   localparam logic [15:0] POS_MAX       = 16'hFFFF;
   localparam logic [7:0]  BRIGHT_FULL   = 8'hFF;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   localparam logic REG_PIXEL_COUNT = 1'b0;
   localparam logic REG_BRIGHTNESS  = 1'b1;

   typedef enum logic [1:0] {
      PH_RED,
      PH_GREEN,
      PH_BLUE
   } phase_type;

   typedef struct packed {
      logic               pix;
      logic               frame;
      logic [INDEX_W-1:0] index;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } cmd_type;

   // c * (b + 1) >> 8, or c unchanged at full brightness
   function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] b);
      logic [16:0] prod;
      prod = {9'd0, c} * ({9'd0, b} + 17'd1);
      if (b == BRIGHT_FULL) return c;
      return prod[15:8];
   endfunction

endpackage

[design/drgb_front.sv]
// Front end: accepts packet bytes, tracks position and triplets, queues commands.
module drgb_front #(
   parameter int MAX_PIXELS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic [15:0]           req_packet_length,
   input  logic                  req_last_byte,
   input  logic [10:0]           pixel_count,
   input  logic                  q_full,
   output logic                  q_push,
   output drgb_pkg::cmd_type     q_cmd
);
   import drgb_pkg::*;

   localparam int NPW  = $clog2(MAX_PIXELS + 1);
   localparam int CMPW = (NPW > 11) ? NPW : 11;
   localparam int MLW  = NPW + 3;
   localparam int LCW  = (MLW > 16) ? MLW : 16;   // length compare width

   logic [15:0]    byte_position_ff, byte_position_in;
   logic           dropping_ff, dropping_in;
   logic [NPW-1:0] next_pixel_ff, next_pixel_in;
   logic [7:0]     held_red_ff, held_red_in;
   logic [7:0]     held_green_ff, held_green_in;
   phase_type      phase_ff, phase_in;

   logic [CMPW-1:0] pc_ext;
   logic [NPW-1:0]  npix;
   logic [MLW-1:0]  max_len;
   logic            accept;
   logic            emit_pix;
   logic            emit_frame;
   logic            len_bad;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign pc_ext  = CMPW'(pixel_count);
   assign npix    = (pc_ext > CMPW'(MAX_PIXELS)) ? NPW'(MAX_PIXELS) : NPW'(pixel_count);
   assign max_len = (MLW'(npix) << 1) + MLW'(npix) + MLW'(2);
   assign len_bad = (LCW'(req_packet_length) > LCW'(max_len)) ||
                    (req_packet_length < MIN_LENGTH);

   always_comb begin
      byte_position_in = byte_position_ff;
      dropping_in      = dropping_ff;
      next_pixel_in    = next_pixel_ff;
      held_red_in      = held_red_ff;
      held_green_in    = held_green_ff;
      phase_in         = phase_ff;
      emit_pix         = 1'b0;
      emit_frame       = 1'b0;
      if (accept) begin
         if (byte_position_ff == 16'd0) begin
            dropping_in   = len_bad || (req_data_byte != PROTOCOL_DRGB) || (npix == '0);
            next_pixel_in = '0;
         end else if (!dropping_ff && byte_position_ff >= 16'd2 &&
                      byte_position_ff < req_packet_length) begin
            case (phase_ff)
               PH_RED:   held_red_in = req_data_byte;
               PH_GREEN: held_green_in = req_data_byte;
               PH_BLUE: begin
                  if (next_pixel_ff < npix) begin
                     emit_pix      = 1'b1;
                     next_pixel_in = next_pixel_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (req_last_byte) begin
            emit_frame       = !dropping_ff && (byte_position_ff >= 16'd2);
            byte_position_in = '0;
            dropping_in      = 1'b0;
            next_pixel_in    = '0;
         end else if (byte_position_ff != POS_MAX) begin
            byte_position_in = byte_position_ff + 16'd1;
            if (byte_position_ff == 16'd1) begin
               phase_in = PH_RED;
            end else begin
               case (phase_ff)
                  PH_RED:   phase_in = PH_GREEN;
                  PH_GREEN: phase_in = PH_BLUE;
                  default:  phase_in = PH_RED;
               endcase
            end
         end
      end
   end

   assign q_push      = emit_pix || emit_frame;
   assign q_cmd.pix   = emit_pix;
   assign q_cmd.frame = emit_frame;
   assign q_cmd.index = INDEX_W'(next_pixel_ff);
   assign q_cmd.red   = held_red_ff;
   assign q_cmd.green = held_green_ff;
   assign q_cmd.blue  = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         dropping_ff      <= 1'b0;
         next_pixel_ff    <= '0;
         phase_ff         <= PH_RED;
      end else begin
         byte_position_ff <= byte_position_in;
         dropping_ff      <= dropping_in;
         next_pixel_ff    <= next_pixel_in;
         phase_ff         <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      held_red_ff   <= held_red_in;
      held_green_ff <= held_green_in;
   end

endmodule

[design/drgb_queue.sv]
// Short command queue between the front end and the output stage.
module drgb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  drgb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output drgb_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import drgb_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[design/drgb_back.sv]
// Back end: scales queued pixels and drives the registered result channel.
module drgb_back #(
   parameter int IDXW = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  drgb_pkg::cmd_type head,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic [7:0]        brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [IDXW-1:0]   rsp_pixel_index,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue
);
   import drgb_pkg::*;

   logic            valid_ff, valid_in;
   logic            sub_ff, sub_in;   // pixel half of a double entry already sent
   logic            kind_ff, kind_in;
   logic [IDXW-1:0] index_ff, index_in;
   logic [7:0]      red_ff, red_in;
   logic [7:0]      green_ff, green_in;
   logic [7:0]      blue_ff, blue_in;
   logic            load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      kind_in  = kind_ff;
      index_in = index_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (head.pix && !sub_ff) begin
               kind_in  = KIND_PIXEL;
               index_in = head.index[IDXW-1:0];
               red_in   = scale_channel(head.red, brightness);
               green_in = scale_channel(head.green, brightness);
               blue_in  = scale_channel(head.blue, brightness);
               sub_in   = head.frame;
               q_pop    = !head.frame;
            end else begin
               kind_in  = KIND_FRAME;
               index_in = '0;
               red_in   = '0;
               green_in = '0;
               blue_in  = '0;
               sub_in   = 1'b0;
               q_pop    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      index_ff <= index_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;

endmodule

[design/drgb_pixel_packet_decoder.sv]
// Top level of the DRGB realtime pixel packet decoder.
//
// req_*: one payload byte per transfer, with the packet length repeated on
//   every byte and req_last_byte on the final one. The first byte decides
//   whether the packet is kept (protocol id 2, length 5 .. pixel_count*3+2).
// rsp_*: pixel writes (kind 0) at indices 0, 1, 2, ... with scaled colors,
//   then one frame-complete result (kind 1) after the last byte of a kept
//   packet. A byte yields zero, one or two results.
// csr_*: index 0 pixel_count, index 1 brightness (255 = unscaled). Write
//   only while the block is idle; csr_ready is always high.
// Throughput: one byte per cycle. The front end takes a byte every cycle
//   while the four-entry command queue has room; the output stage sends one
//   result per cycle while the receiver is ready, so the final byte of a
//   packet that also closes a pixel gives the output two results to send.
// Path: a transferred byte's command is written into the queue, then
//   loaded into the output register, where rsp_valid rises; the result
//   transfers once the receiver is ready.
// Reset clears packet position, queue and output valid; pixel_count goes to
//   0 and brightness to 255. If the receiver stalls, the output register
//   holds, the queue fills and req_ready drops once it is full.
module drgb_pixel_packet_decoder #(
   parameter int MAX_PIXELS = 1024,
   localparam int IDXW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   input  logic [15:0]     req_packet_length,
   input  logic            req_last_byte,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_kind,
   output logic [IDXW-1:0] rsp_pixel_index,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [10:0]     csr_data
);
   import drgb_pkg::*;

   logic [10:0] pixel_count_ff, pixel_count_in;
   logic [7:0]  brightness_ff, brightness_in;
   logic        q_push;
   logic        q_pop;
   logic        q_empty;
   logic        q_full;
   cmd_type     q_cmd;
   cmd_type     q_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      pixel_count_in = pixel_count_ff;
      brightness_in  = brightness_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PIXEL_COUNT: pixel_count_in = csr_data;
            REG_BRIGHTNESS:  brightness_in  = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= '0;
         brightness_ff  <= BRIGHT_FULL;
      end else begin
         pixel_count_ff <= pixel_count_in;
         brightness_ff  <= brightness_in;
      end
   end

   drgb_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_packet_length (req_packet_length),
      .req_last_byte     (req_last_byte),
      .pixel_count       (pixel_count_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (q_cmd)
   );

   drgb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   drgb_back #(
      .IDXW(IDXW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .brightness      (brightness_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue)
   );

endmodule

[design/drgb_checker.sv]
// Port-level checker for the DRGB packet decoder, bound to the top level.
`include "drgb_pixel_packet_decoder_macros.svh"

module drgb_checker #(
   parameter int MAX_PIXELS = 1024,
   localparam int IDXW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_kind,
   input logic [IDXW-1:0] rsp_pixel_index,
   input logic [7:0]      rsp_red,
   input logic [7:0]      rsp_green,
   input logic [7:0]      rsp_blue
);
   import drgb_pkg::*;

   logic             prev_pix_ff;
   logic [IDXW-1:0]  prev_idx_ff;
   logic             rsp_xfer;
   logic             stall;
   logic [IDXW+24:0] payload;
   logic             frame_out;
   logic             frame_clear;
   logic             pix_after_pix;
   logic             idx_in_seq;

   assign rsp_xfer      = rsp_valid && rsp_ready;
   assign stall         = rsp_valid && !rsp_ready;
   assign payload       = {rsp_kind, rsp_pixel_index, rsp_red, rsp_green, rsp_blue};
   assign frame_out     = rsp_valid && (rsp_kind == KIND_FRAME);
   assign frame_clear   = (rsp_pixel_index == '0) && (rsp_red == 8'd0) &&
                          (rsp_green == 8'd0) && (rsp_blue == 8'd0);
   assign pix_after_pix = rsp_xfer && (rsp_kind == KIND_PIXEL) && prev_pix_ff;
   assign idx_in_seq    = (rsp_pixel_index == IDXW'(prev_idx_ff + 1'b1)) ||
                          (rsp_pixel_index == '0);

   // last transferred result, for the index sequence check
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pix_ff <= 1'b0;
         prev_idx_ff <= '0;
      end else if (rsp_xfer) begin
         prev_pix_ff <= (rsp_kind == KIND_PIXEL);
         prev_idx_ff <= rsp_pixel_index;
      end
   end

   `DRGB_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_valid, "rsp_valid dropped in stall")

   `DRGB_ASSERT_NEXT(a_rsp_stable, clock, reset, stall, $stable(payload), "stalled payload moved")

   `DRGB_ASSERT_IMPL(a_frame_zero, clock, reset, frame_out, frame_clear, "nonzero frame fields")

   `DRGB_ASSERT_IMPL(a_index_seq, clock, reset, pix_after_pix, idx_in_seq, "index out of sequence")

endmodule

bind drgb_pixel_packet_decoder drgb_checker #(.MAX_PIXELS(MAX_PIXELS)) u_drgb_checker (.*);
